[rtl/core/ppm_fg_pkg.sv]
package ppm_fg_pkg;

  // Number of servo channels in one frame.
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Field widths.
  localparam int unsigned US_W    = 16;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned PTR_W   = 4;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Configuration reset values.
  localparam logic [US_W-1:0]  FRAME_PERIOD_RST = 16'd22500;
  localparam logic [US_W-1:0]  SYNC_PULSE_RST   = 16'd400;
  localparam logic [US_W-1:0]  MIN_PULSE_RST    = 16'd1000;
  localparam logic [US_W-1:0]  MAX_PULSE_RST    = 16'd2000;
  localparam logic [US_W-1:0]  IDLE_PULSE_RST   = 16'd1000;
  localparam logic [DIV_W-1:0] SUP_DIVIDE_RST   = 8'd50;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_SET_CHANNEL = 2'd0,
    REQ_PERIOD_END  = 2'd1,
    REQ_SUP_TICK    = 2'd2
  } req_type_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PULSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PULSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUP_DIVIDE   = 3'd5;

endpackage

[rtl/core/ppm_frame_generator_unit.sv]
// PPM frame generator. Each input item is one event: a channel set, a
// timer period end, or a supervisor tick. Every accepted item produces
// exactly one result item in the next cycle, carrying an optional new timer
// period (load_valid, pulse_width_us), the stream enable, the marker compare
// value and the tracking status. A set clamps the position into the min/max
// range (lower bound first) and stores it; sets to channels at or above the
// channel count are dropped. Period ends walk the channels, then emit the
// sync gap (frame period minus the accumulated sum, floored at zero). If a
// supervisor window passes without a fresh set, tracking drops, and at the
// next frame boundary the stream stops and all channels go back to the idle
// value. The block takes one item per clock: all event logic sits between
// the input handshake and a single result register, and a new item is taken
// whenever the result register is empty or is being drained in that cycle.
// Configuration writes take effect on the next clock and must only be done
// while no result is pending.
module ppm_frame_generator_unit
  import ppm_fg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [US_W-1:0]      cfg_data,
  // Input item channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [3:0]           in_channel_index,
  input  logic [US_W-1:0]      in_position_us,
  // Result item channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_load_valid,
  output logic [US_W-1:0]      out_pulse_width_us,
  output logic                 out_output_enabled,
  output logic [US_W-1:0]      out_compare_us,
  output logic                 out_tracking_active
);

  // Configuration registers.
  logic [US_W-1:0]  frame_period_r;
  logic [US_W-1:0]  sync_pulse_r;
  logic [US_W-1:0]  min_pulse_r;
  logic [US_W-1:0]  max_pulse_r;
  logic [US_W-1:0]  idle_pulse_r;
  logic [DIV_W-1:0] sup_divide_r;

  // Frame state.
  logic [US_W-1:0]  chan_r [NUM_CHANNELS];
  logic [US_W-1:0]  chan_nxt [NUM_CHANNELS];
  logic [SUM_W-1:0] frame_sum_r, frame_sum_nxt;
  logic [PTR_W-1:0] chan_ptr_r, chan_ptr_nxt;
  logic [DIV_W-1:0] tick_div_r, tick_div_nxt;
  logic             fresh_r, fresh_nxt;
  logic             tracking_r, tracking_nxt;
  logic             enabled_r, enabled_nxt;

  // Result register.
  logic             out_valid_r;
  logic             load_r, load_nxt;
  logic [US_W-1:0]  width_r, width_nxt;
  logic             out_en_r;
  logic [US_W-1:0]  compare_r;
  logic             out_trk_r;

  logic             accept;
  logic [US_W-1:0]  pos_lo;
  logic [US_W-1:0]  pos_clamped;
  logic [SUM_W:0]   sum_ext;
  logic [DIV_W-1:0] tick_inc;

  // The result register frees up either when empty or when drained now.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Lower clamp first, then upper, so an inverted range yields the max.
  assign pos_lo      = (in_position_us < min_pulse_r) ? min_pulse_r : in_position_us;
  assign pos_clamped = (pos_lo > max_pulse_r) ? max_pulse_r : pos_lo;

  assign sum_ext  = {1'b0, frame_sum_r} + {{(SUM_W + 1 - US_W){1'b0}},
                                           chan_r[chan_ptr_r[CH_IDX_W-1:0]]};
  assign tick_inc = tick_div_r + 1'b1;

  always_comb begin
    chan_nxt      = chan_r;
    frame_sum_nxt = frame_sum_r;
    chan_ptr_nxt  = chan_ptr_r;
    tick_div_nxt  = tick_div_r;
    fresh_nxt     = fresh_r;
    tracking_nxt  = tracking_r;
    enabled_nxt   = enabled_r;
    load_nxt      = 1'b0;
    width_nxt     = '0;

    case (in_req_type)
      REQ_SET_CHANNEL: begin
        if (in_channel_index < PTR_W'(NUM_CHANNELS)) begin
          chan_nxt[in_channel_index[CH_IDX_W-1:0]] = pos_clamped;
          fresh_nxt = 1'b1;
          if (!tracking_r) begin
            tracking_nxt = 1'b1;
            enabled_nxt  = 1'b1;
          end
        end
      end
      REQ_PERIOD_END: begin
        if (enabled_r) begin
          if (chan_ptr_r == '0 && !tracking_r) begin
            // Frame boundary with tracking lost: stop and park channels.
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              chan_nxt[i] = idle_pulse_r;
            end
            enabled_nxt = 1'b0;
          end else if (chan_ptr_r >= PTR_W'(NUM_CHANNELS)) begin
            // Sync gap closes the frame.
            if (frame_sum_r >= {{(SUM_W - US_W){1'b0}}, frame_period_r}) begin
              width_nxt = '0;
            end else begin
              width_nxt = frame_period_r - frame_sum_r[US_W-1:0];
            end
            chan_ptr_nxt  = '0;
            frame_sum_nxt = '0;
            load_nxt      = 1'b1;
          end else begin
            width_nxt     = chan_r[chan_ptr_r[CH_IDX_W-1:0]];
            chan_ptr_nxt  = chan_ptr_r + 1'b1;
            frame_sum_nxt = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            load_nxt      = 1'b1;
          end
        end
      end
      REQ_SUP_TICK: begin
        tick_div_nxt = tick_inc;
        if (tick_inc >= sup_divide_r) begin
          tick_div_nxt = '0;
          if (!fresh_r) begin
            tracking_nxt = 1'b0;
          end
          fresh_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= FRAME_PERIOD_RST;
      sync_pulse_r   <= SYNC_PULSE_RST;
      min_pulse_r    <= MIN_PULSE_RST;
      max_pulse_r    <= MAX_PULSE_RST;
      idle_pulse_r   <= IDLE_PULSE_RST;
      sup_divide_r   <= SUP_DIVIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_PERIOD: frame_period_r <= cfg_data;
        CFG_SYNC_PULSE:   sync_pulse_r   <= cfg_data;
        CFG_MIN_PULSE:    min_pulse_r    <= cfg_data;
        CFG_MAX_PULSE:    max_pulse_r    <= cfg_data;
        CFG_IDLE_PULSE:   idle_pulse_r   <= cfg_data;
        CFG_SUP_DIVIDE:   sup_divide_r   <= cfg_data[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Event state, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= IDLE_PULSE_RST;
      end
      frame_sum_r <= '0;
      chan_ptr_r  <= '0;
      tick_div_r  <= '0;
      fresh_r     <= 1'b0;
      tracking_r  <= 1'b0;
      enabled_r   <= 1'b0;
    end else if (accept) begin
      chan_r      <= chan_nxt;
      frame_sum_r <= frame_sum_nxt;
      chan_ptr_r  <= chan_ptr_nxt;
      tick_div_r  <= tick_div_nxt;
      fresh_r     <= fresh_nxt;
      tracking_r  <= tracking_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Result payload; status reflects the state after the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      load_r    <= load_nxt;
      width_r   <= width_nxt;
      out_en_r  <= enabled_nxt;
      compare_r <= enabled_nxt ? sync_pulse_r : '0;
      out_trk_r <= tracking_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_load_valid      = load_r;
  assign out_pulse_width_us  = width_r;
  assign out_output_enabled  = out_en_r;
  assign out_compare_us      = compare_r;
  assign out_tracking_active = out_trk_r;

endmodule

[rtl/core/ppm_fg_checker.sv]
module ppm_fg_checker
  import ppm_fg_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           in_req_type,
  input logic [3:0]           in_channel_index,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_load_valid,
  input logic [US_W-1:0]      out_pulse_width_us,
  input logic                 out_output_enabled,
  input logic [US_W-1:0]      out_compare_us,
  input logic                 out_tracking_active
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_width_us)
      && $stable(out_load_valid))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stopped stream shows no marker compare value.
  a_compare_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_output_enabled |-> out_compare_us == '0)
    else $error("compare value while disabled");

  // Without a load the width is zero.
  a_no_load_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_load_valid |-> out_pulse_width_us == '0)
    else $error("width without load");

  // A valid channel set leaves tracking on and the stream running.
  a_set_enables: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_SET_CHANNEL
      && in_channel_index < 4'(NUM_CHANNELS)
    |=> out_valid && out_tracking_active && out_output_enabled)
    else $error("set did not enable tracking");

endmodule

bind ppm_frame_generator_unit ppm_fg_checker u_ppm_fg_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ppm_fg_pkg::*;

  // The request field is two bits wide, so the fourth code exists on the wire
  // even though the block defines no meaning for it. It must change nothing.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // This bound covers worst-case gaps and stalls on every item several times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 176;

  // One result item as seen on the output port.
  typedef struct packed {
    logic            load;
    logic [US_W-1:0] width;
    logic            enabled;
    logic [US_W-1:0] compare;
    logic            tracking;
  } frame_result_t;

  // Keeps a private copy of the frame generator state and the registers,
  // works out the result of every accepted item, and checks the results
  // in order against what the block delivers.
  class ppm_frame_scoreboard;
    logic [US_W-1:0]  frame_period, sync_pulse, min_pulse, max_pulse, idle_pulse;
    logic [DIV_W-1:0] sup_divide;
    logic [US_W-1:0]  chan_width [NUM_CHANNELS];
    logic [SUM_W-1:0] frame_sum;
    logic [PTR_W-1:0] chan_ptr;
    logic [DIV_W-1:0] tick_count;
    bit               fresh, tracking, enabled;
    frame_result_t    frame_results_q[$];
    int unsigned      fail_count;

    function new();
      frame_period = FRAME_PERIOD_RST;
      sync_pulse   = SYNC_PULSE_RST;
      min_pulse    = MIN_PULSE_RST;
      max_pulse    = MAX_PULSE_RST;
      idle_pulse   = IDLE_PULSE_RST;
      sup_divide   = SUP_DIVIDE_RST;
      foreach (chan_width[i]) chan_width[i] = IDLE_PULSE_RST;
      frame_sum  = '0;
      chan_ptr   = '0;
      tick_count = '0;
      fresh      = 0;
      tracking   = 0;
      enabled    = 0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [US_W-1:0] data);
      case (index)
        CFG_FRAME_PERIOD: frame_period = data;
        CFG_SYNC_PULSE:   sync_pulse   = data;
        CFG_MIN_PULSE:    min_pulse    = data;
        CFG_MAX_PULSE:    max_pulse    = data;
        CFG_IDLE_PULSE:   idle_pulse   = data;
        CFG_SUP_DIVIDE:   sup_divide   = data[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return frame_results_q.size();
    endfunction

    // Advances the state by one accepted item and queues the result it causes.
    function void note_item(logic [1:0] req, logic [3:0] idx, logic [US_W-1:0] pos);
      frame_result_t   r;
      logic [US_W-1:0] p;
      logic [SUM_W:0]  s;
      r = '0;
      p = pos;
      case (req)
        REQ_SET_CHANNEL: begin
          if (idx < NUM_CHANNELS) begin
            // Lower bound first, so an inverted range yields the upper bound.
            if (p < min_pulse) p = min_pulse;
            if (p > max_pulse) p = max_pulse;
            fresh = 1;
            if (!tracking) begin
              tracking = 1;
              enabled  = 1;
            end
            chan_width[idx] = p;
          end
        end
        REQ_PERIOD_END: begin
          if (enabled) begin
            if (chan_ptr == 0 && !tracking) begin
              foreach (chan_width[i]) chan_width[i] = idle_pulse;
              enabled = 0;
            end else if (chan_ptr >= NUM_CHANNELS) begin
              r.load  = 1;
              r.width = (frame_sum >= frame_period) ? '0
                                                    : frame_period - frame_sum[US_W-1:0];
              chan_ptr  = '0;
              frame_sum = '0;
            end else begin
              r.load    = 1;
              r.width   = chan_width[chan_ptr];
              chan_ptr  = chan_ptr + 1'b1;
              s         = {1'b0, frame_sum} + r.width;
              frame_sum = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
            end
          end
        end
        REQ_SUP_TICK: begin
          tick_count = tick_count + 1'b1;
          if (tick_count >= sup_divide) begin
            tick_count = '0;
            if (!fresh) tracking = 0;
            fresh = 0;
          end
        end
        default: ;
      endcase
      r.enabled  = enabled;
      r.compare  = enabled ? sync_pulse : '0;
      r.tracking = tracking;
      frame_results_q.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got_v);
      if (want != got_v) begin
        fail_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got_v);
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (frame_results_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = frame_results_q.pop_front();
      compare_field("load_valid", want.load, got.load);
      compare_field("pulse_width_us", want.width, got.width);
      compare_field("output_enabled", want.enabled, got.enabled);
      compare_field("compare_us", want.compare, got.compare);
      compare_field("tracking_active", want.tracking, got.tracking);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [US_W-1:0]      cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_req_type;
  logic [3:0]           in_channel_index;
  logic [US_W-1:0]      in_position_us;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_load_valid;
  logic [US_W-1:0]      out_pulse_width_us;
  logic                 out_output_enabled;
  logic [US_W-1:0]      out_compare_us;
  logic                 out_tracking_active;

  ppm_frame_scoreboard sb;

  // Shared pacing controls. When no_gaps is set, both sides run flat out.
  // hold_off makes the receiver refuse results for a long stretch.
  bit          no_gaps;
  bit          start_hold;
  bit          hold_off;
  int unsigned stall_left;
  int unsigned cycle_count;

  ppm_frame_generator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_channel_index    (in_channel_index),
    .in_position_us      (in_position_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_load_valid      (out_load_valid),
    .out_pulse_width_us  (out_pulse_width_us),
    .out_output_enabled  (out_output_enabled),
    .out_compare_us      (out_compare_us),
    .out_tracking_active (out_tracking_active)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Must be called at a falling edge. Valid is left high so that a following
  // item with no gap simply replaces the payload.
  task automatic send_item(input logic [1:0] req, input logic [3:0] idx,
                           input logic [US_W-1:0] pos);
    int unsigned gap;
    gap = (no_gaps || hold_off) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = req;
    in_channel_index = idx;
    in_position_us   = pos;
    // Values read right at the rising edge are those the block sampled.
    do @(posedge clk); while (!in_ready);
    sb.note_item(req, idx, pos);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] index, input logic [US_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    sb.write_reg(index, data);
  endtask

  // Stops offering items, lets every pending result drain, then rewrites all
  // six registers. The block registers each result in the cycle after taking its
  // item, so an empty expectation queue means it is idle.
  task automatic apply_settings(input logic [US_W-1:0] period, input logic [US_W-1:0] sync,
                                input logic [US_W-1:0] lo, input logic [US_W-1:0] hi,
                                input logic [US_W-1:0] idle, input logic [DIV_W-1:0] div);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    write_config(CFG_FRAME_PERIOD, period);
    write_config(CFG_SYNC_PULSE, sync);
    write_config(CFG_MIN_PULSE, lo);
    write_config(CFG_MAX_PULSE, hi);
    write_config(CFG_IDLE_PULSE, idle);
    // Only the low byte counts for the divider; the upper byte is noise.
    write_config(CFG_SUP_DIVIDE, {8'($urandom), div});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Walks through the corner cases one by one with the supervisor window set
  // to a single tick, so that tracking loss is quick to provoke.
  task automatic run_directed();
    // A period end before anything was set finds the stream stopped.
    send_item(REQ_PERIOD_END, 4'd0, 16'd0);
    send_item(REQ_UNKNOWN, 4'hF, 16'hFFFF);
    // Positions at both extremes get clamped; the first set starts the stream.
    send_item(REQ_SET_CHANNEL, 4'd0, 16'd0);
    send_item(REQ_SET_CHANNEL, 4'd1, 16'hFFFF);
    // Channels at or beyond the channel count are dropped.
    send_item(REQ_SET_CHANNEL, 4'd15, 16'd1500);
    send_item(REQ_SET_CHANNEL, 4'd7, 16'd1500);
    send_item(REQ_SET_CHANNEL, 4'd8, 16'd1200);
    // One whole frame: every channel, then the sync gap.
    repeat (NUM_CHANNELS + 1) send_item(REQ_PERIOD_END, 4'd0, 16'd0);
    // The first window saw a set, the second did not, so tracking drops.
    send_item(REQ_SUP_TICK, 4'd0, 16'd0);
    send_item(REQ_SUP_TICK, 4'd0, 16'd0);
    // At the frame boundary the stream stops, then further ends are ignored.
    send_item(REQ_PERIOD_END, 4'd0, 16'd0);
    send_item(REQ_PERIOD_END, 4'd0, 16'd0);
    // A new set restarts the stream from the kept frame position.
    send_item(REQ_SET_CHANNEL, 4'd3, 16'd1234);
    send_item(REQ_PERIOD_END, 4'd0, 16'd0);
  endtask

  // Random traffic in segments. Active segments mix sets, period ends and
  // ticks like a live link; quiet segments carry no sets, so supervisor
  // windows expire and the stream stops and later restarts.
  task automatic run_random_phase(input int unsigned n_items, input bit with_hold);
    int unsigned seg_left;
    int unsigned roll;
    bit          quiet;
    logic [3:0]  idx;
    logic [US_W-1:0] pos;
    seg_left = 0;
    quiet    = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        quiet    = ($urandom_range(0, 2) == 0);
        no_gaps  = ($urandom_range(0, 4) == 0);
        seg_left = $urandom_range(5, 30);
      end
      seg_left--;
      if (with_hold && k == n_items / 4) start_hold = 1'b1;
      idx  = 4'($urandom);
      pos  = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 35 && !quiet) begin
        idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                          : 4'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0: pos = sb.min_pulse + 16'($urandom_range(0, 4)) - 16'd2;
          1: pos = sb.max_pulse + 16'($urandom_range(0, 4)) - 16'd2;
          2: pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: ;
        endcase
        send_item(REQ_SET_CHANNEL, idx, pos);
      end else if (roll < 78) begin
        send_item(REQ_PERIOD_END, idx, pos);
      end else if (roll < 96) begin
        send_item(REQ_SUP_TICK, idx, pos);
      end else begin
        send_item(REQ_UNKNOWN, idx, pos);
      end
    end
    no_gaps = 0;
  endtask

  // Receiver: after each result it stalls for a drawn number of cycles, and
  // refuses everything while a long hold-off is in force.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off || stall_left > 0) begin
        out_ready = 1'b0;
        if (!hold_off) stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result monitor. Checks every accepted result and draws the next stall.
  initial begin : result_monitor
    frame_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.load     = out_load_valid;
        got.width    = out_pulse_width_us;
        got.enabled  = out_output_enabled;
        got.compare  = out_compare_us;
        got.tracking = out_tracking_active;
        sb.check_result(got);
        stall_left = no_gaps ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // Long receiver hold-off, counted here on its own. The sender keeps
  // offering items without gaps meanwhile, so the block must stall its input.
  initial begin
    hold_off = 1'b0;
    wait (start_hold);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog. Reaching the end of this block means the run hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_FRAME_PERIOD;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_SET_CHANNEL;
    in_channel_index = '0;
    in_position_us   = '0;
    no_gaps          = 0;
    start_hold       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apply_settings(FRAME_PERIOD_RST, SYNC_PULSE_RST, MIN_PULSE_RST, MAX_PULSE_RST,
                   IDLE_PULSE_RST, 8'd1);
    run_directed();

    // Nominal servo timing with a short window; the hold-off happens here.
    apply_settings(16'd22500, 16'd400, 16'd1000, 16'd2000, 16'd1000, 8'd3);
    run_random_phase(PHASE_ITEMS, 1'b1);

    // Widest clamp range and a zero frame period, so every sync gap
    // saturates at zero; the longest supervisor window.
    apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255);
    run_random_phase(PHASE_ITEMS, 1'b0);

    // Inverted clamp range, zero idle and sync, and a divider of zero that
    // closes a window on every tick.
    apply_settings(16'hFFFF, 16'd0, 16'd3000, 16'd1000, 16'd0, 8'd0);
    run_random_phase(PHASE_ITEMS, 1'b0);

    // Random settings around the usual operating point.
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(500, 1500)),
                   16'($urandom_range(1500, 2500)), 16'($urandom),
                   8'($urandom_range(1, 8)));
    run_random_phase(PHASE_ITEMS, 1'b0);

    // Back to the power-up values.
    apply_settings(FRAME_PERIOD_RST, SYNC_PULSE_RST, MIN_PULSE_RST, MAX_PULSE_RST,
                   IDLE_PULSE_RST, SUP_DIVIDE_RST);
    run_random_phase(PHASE_ITEMS, 1'b0);

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
